/* design/max_tracking_queue_top_defines.svh */
// ----------------------------------------------------------------------------
// Max tracking queue assertion macros
// Shared concurrent assertion helpers for the queue design.
// ----------------------------------------------------------------------------
`ifndef MAX_TRACKING_QUEUE_TOP_DEFINES_SVH
`define MAX_TRACKING_QUEUE_TOP_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define MTQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define MTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* design/mtq_pkg.sv */
// ----------------------------------------------------------------------------
// Max tracking queue package
// Shared widths, codes and helpers.
// ----------------------------------------------------------------------------
package mtq_pkg;

  localparam int unsigned Depth = 1024;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DEQ  = 2'd1,
    MODE_INSP = 2'd2,
    MODE_RSVD = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_XFER_RD,
    BK_XFER_WR,
    BK_POP,
    BK_RESP
  } bk_state_e;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] value;
  } cmd_t;

  function automatic logic [31:0] smax(input logic [31:0] a, input logic [31:0] b);
    smax = ($signed(a) >= $signed(b)) ? a : b;
  endfunction

endpackage

/* design/mtq_front.sv */
// ----------------------------------------------------------------------------
// Max tracking queue front end
// Accepts commands and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module mtq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    mode_i,
  input  logic [31:0]   value_i,
  output logic          busy_o,
  output logic          cmd_valid_o,
  output mtq_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);

  mtq_pkg::cmd_t fifo_q [2];
  logic          rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push;

  assign busy_o      = (cnt_q == 2'd2);
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    rd_ptr_d = rd_ptr_q ^ cmd_pop_i;
    wr_ptr_d = wr_ptr_q ^ push;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{mode: mtq_pkg::mode_e'(mode_i), value: value_i};
    end
  end

endmodule

/* design/mtq_back.sv */
// ----------------------------------------------------------------------------
// Max tracking queue back end
// Executes commands on the two stacks and produces results.
// ----------------------------------------------------------------------------
`include "max_tracking_queue_top_defines.svh"

module mtq_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  mtq_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          done_o,
  output logic [31:0]   dequeued_o,
  output logic [31:0]   max_value_o,
  output logic          max_valid_o,
  output logic          is_empty_o,
  output logic [1:0]    status_o
);

  localparam int unsigned AW = mtq_pkg::AddrW;
  localparam int unsigned CW = mtq_pkg::CntW;
  localparam logic [CW-1:0] DepthC = CW'(mtq_pkg::Depth);

  logic [63:0] in_mem  [mtq_pkg::Depth];
  logic [63:0] out_mem [mtq_pkg::Depth];

  mtq_pkg::bk_state_e state_q, state_d;
  logic [CW-1:0] in_cnt_q, in_cnt_d, out_cnt_q, out_cnt_d;
  logic [31:0]   in_top_q, in_top_d, out_top_q, out_top_d;
  logic [31:0]   deq_q, deq_d;
  logic [1:0]    st_q, st_d;
  logic [31:0]   xv_q, xv_d;
  logic [63:0]   in_rd_q, out_rd_q;
  logic          in_we, out_we, in_re, out_re;
  logic [AW-1:0] in_wa, out_wa, in_ra, out_ra;
  logic [63:0]   in_wd, out_wd;
  logic [31:0]   m;

  always_comb begin
    state_d   = state_q;
    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    in_top_d  = in_top_q;
    out_top_d = out_top_q;
    deq_d     = deq_q;
    st_d      = st_q;
    xv_d      = xv_q;
    cmd_pop_o = 1'b0;
    done_o    = 1'b0;
    in_we = 1'b0; out_we = 1'b0; in_re = 1'b0; out_re = 1'b0;
    in_wa  = in_cnt_q[AW-1:0];
    out_wa = out_cnt_q[AW-1:0];
    in_ra  = AW'(in_cnt_q - CW'(1));
    out_ra = AW'(out_cnt_q - CW'(1));
    m      = (in_cnt_q == '0) ? cmd_i.value : mtq_pkg::smax(cmd_i.value, in_top_q);
    in_wd  = {cmd_i.value, m};
    out_wd = {xv_q, (out_cnt_q == '0) ? xv_q : mtq_pkg::smax(xv_q, out_top_q)};
    case (state_q)
      mtq_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          deq_d = '0;
          st_d  = mtq_pkg::ST_OK;
          case (cmd_i.mode)
            mtq_pkg::MODE_ENQ: begin
              if (in_cnt_q == DepthC) begin
                st_d = mtq_pkg::ST_FULL;
              end else begin
                in_we    = 1'b1;
                in_top_d = m;
                in_cnt_d = in_cnt_q + CW'(1);
              end
              state_d = mtq_pkg::BK_RESP;
            end
            mtq_pkg::MODE_DEQ: begin
              if (in_cnt_q == '0 && out_cnt_q == '0) begin
                st_d    = mtq_pkg::ST_EMPTY;
                state_d = mtq_pkg::BK_RESP;
              end else if (out_cnt_q == '0) begin
                in_re   = 1'b1;
                state_d = mtq_pkg::BK_XFER_RD;
              end else begin
                out_re  = 1'b1;
                state_d = mtq_pkg::BK_POP;
              end
            end
            default: state_d = mtq_pkg::BK_RESP;
          endcase
        end
      end
      mtq_pkg::BK_XFER_RD: begin
        // in_rd_q holds the entry at in_cnt-1
        xv_d     = in_rd_q[63:32];
        in_cnt_d = in_cnt_q - CW'(1);
        state_d  = mtq_pkg::BK_XFER_WR;
      end
      mtq_pkg::BK_XFER_WR: begin
        out_we    = 1'b1;
        out_top_d = out_wd[31:0];
        out_cnt_d = out_cnt_q + CW'(1);
        if (in_cnt_q != '0 && out_cnt_q + CW'(1) != DepthC) begin
          in_re   = 1'b1;
          state_d = mtq_pkg::BK_XFER_RD;
        end else begin
          // read back the entry being written; the read port forwards it
          out_re  = 1'b1;
          out_ra  = out_cnt_q[AW-1:0];
          state_d = mtq_pkg::BK_POP;
        end
      end
      mtq_pkg::BK_POP: begin
        // out_rd_q is the top; fetch the new top's prefix max
        deq_d     = out_rd_q[63:32];
        out_cnt_d = out_cnt_q - CW'(1);
        out_re    = (out_cnt_q > CW'(1));
        out_ra    = AW'(out_cnt_q - CW'(2));
        state_d   = mtq_pkg::BK_RESP;
      end
      mtq_pkg::BK_RESP: begin
        done_o  = 1'b1;
        state_d = mtq_pkg::BK_IDLE;
      end
      default: state_d = mtq_pkg::BK_IDLE;
    endcase
  end

  // after a pop the new top prefix max arrives in out_rd_q during RESP
  logic pop_rd_q;
  logic [31:0] out_top_eff;
  assign out_top_eff = pop_rd_q ? out_rd_q[31:0] : out_top_q;

  always_comb begin
    dequeued_o  = deq_q;
    status_o    = st_q;
    max_valid_o = (in_cnt_q != '0) || (out_cnt_q != '0);
    is_empty_o  = !max_valid_o;
    if (in_cnt_q != '0 && out_cnt_q != '0) max_value_o = mtq_pkg::smax(in_top_q, out_top_eff);
    else if (in_cnt_q != '0)               max_value_o = in_top_q;
    else if (out_cnt_q != '0)              max_value_o = out_top_eff;
    else                                   max_value_o = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mtq_pkg::BK_IDLE;
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      pop_rd_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_cnt_q  <= in_cnt_d;
      out_cnt_q <= out_cnt_d;
      pop_rd_q  <= (state_q == mtq_pkg::BK_POP) && out_re;
    end
  end

  always_ff @(posedge clk_i) begin
    in_top_q  <= in_top_d;
    out_top_q <= pop_rd_q ? out_rd_q[31:0] : out_top_d;
    deq_q     <= deq_d;
    st_q      <= st_d;
    xv_q      <= xv_d;
    if (in_we)  in_mem[in_wa]   <= in_wd;
    if (out_we) out_mem[out_wa] <= out_wd;
    if (in_re)  in_rd_q  <= in_mem[in_ra];
    if (out_re) out_rd_q <= (out_we && out_ra == out_wa) ? out_wd : out_mem[out_ra];
  end

  // A transfer starts with the output stack empty and moves the whole input
  // stack, so the input stack is empty afterwards and in_top_q needs no refresh.

  `MTQ_ASSERT_IMP(a_in_bound, clk_i, rst_ni, 1'b1, in_cnt_q <= DepthC)
  `MTQ_ASSERT_IMP(a_out_bound, clk_i, rst_ni, 1'b1, out_cnt_q <= DepthC)
  `MTQ_ASSERT_NEXT(a_resp_idle, clk_i, rst_ni, done_o, state_q == mtq_pkg::BK_IDLE)
  `MTQ_ASSERT_IMP(a_pop_idle, clk_i, rst_ni, cmd_pop_o, state_q == mtq_pkg::BK_IDLE)

endmodule

/* design/max_tracking_queue_top.sv */
// ----------------------------------------------------------------------------
// Max tracking queue top level
// FIFO of signed 32-bit values built from two stacks, reporting its maximum.
// Enqueue, inspect and empty dequeue go from IDLE to RESP; a dequeue from a
// filled output stack passes through POP before RESP; a refilling dequeue first
// runs XFER_RD and XFER_WR for each moved entry. The back end takes one command
// at a time while the front queue holds up to two more; the receiver cannot
// stall. Reset clears both counts; memories need no clearing.
// ----------------------------------------------------------------------------
module max_tracking_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [31:0] dequeued_o,
  output logic [31:0] max_value_o,
  output logic        max_valid_o,
  output logic        is_empty_o,
  output logic [1:0]  status_o
);

  logic          cmd_valid, cmd_pop;
  mtq_pkg::cmd_t cmd;

  // Front: capture each transaction into a two-entry command queue.
  mtq_front u_front (
    .clk_i, .rst_ni, .start_i(start), .mode_i, .value_i, .busy_o(busy),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  // Back: run the stack operations, including the refill transfer.
  mtq_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .done_o, .dequeued_o, .max_value_o, .max_valid_o, .is_empty_o, .status_o
  );

endmodule
